/* rtl/cmob_pkg.sv */
package cmob_pkg;

	localparam int MAX_DIM = 4096;
	localparam int MAX_ICON = 256;

	localparam int NUM_REGS = 6;
	localparam int ADDR_W = $clog2(4 * NUM_REGS);
	localparam int NUM_STAGES = 4;

	localparam logic [7:0] ICON_MASK = 8'(MAX_ICON - 1);
	localparam logic [7:0] ALPHA_MAX = 8'hff;

	typedef enum logic [2:0] {
		REG_FG_ARGB    = 3'd0,
		REG_ORIGIN_X   = 3'd1,
		REG_ORIGIN_Y   = 3'd2,
		REG_BUF_WIDTH  = 3'd3,
		REG_BUF_HEIGHT = 3'd4,
		REG_ROW_STRIDE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  icon_col;
		logic [7:0]  icon_row;
		logic [7:0]  coverage;
		logic [31:0] dest_pixel;
	} pix_item_t;

	typedef struct packed {
		logic        write_enable;
		logic [23:0] pixel_address;
		logic [31:0] out_pixel;
	} res_item_t;

	typedef struct packed {
		logic [31:0] fg_argb;
		logic [12:0] origin_x;
		logic [12:0] origin_y;
		logic [12:0] buf_width;
		logic [12:0] buf_height;
		logic [12:0] row_stride;
	} cfg_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} pipe_ctl_t;

	// Exact quotient by 255 for any product of two 8-bit values.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

	function automatic logic [12:0] clamp_dim(input logic [12:0] d);
		return (32'(d) > MAX_DIM) ? 13'(MAX_DIM) : d;
	endfunction

endpackage

/* rtl/cmob_regs.sv */
module cmob_regs
	import cmob_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	logic     wr;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_FG_ARGB: begin
					cfg_q.fg_argb <= pwdata;
				end
				REG_ORIGIN_X: begin
					cfg_q.origin_x <= pwdata[12:0];
				end
				REG_ORIGIN_Y: begin
					cfg_q.origin_y <= pwdata[12:0];
				end
				REG_BUF_WIDTH: begin
					cfg_q.buf_width <= pwdata[12:0];
				end
				REG_BUF_HEIGHT: begin
					cfg_q.buf_height <= pwdata[12:0];
				end
				REG_ROW_STRIDE: begin
					cfg_q.row_stride <= pwdata[12:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FG_ARGB:    prdata = cfg_q.fg_argb;
			REG_ORIGIN_X:   prdata = {19'd0, cfg_q.origin_x};
			REG_ORIGIN_Y:   prdata = {19'd0, cfg_q.origin_y};
			REG_BUF_WIDTH:  prdata = {19'd0, cfg_q.buf_width};
			REG_BUF_HEIGHT: prdata = {19'd0, cfg_q.buf_height};
			REG_ROW_STRIDE: prdata = {19'd0, cfg_q.row_stride};
			default:        prdata = '0;
		endcase
	end

endmodule

/* rtl/cmob_pipe_ctl.sv */
module cmob_pipe_ctl
	import cmob_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pix_valid,
	output logic      pix_ready,
	output logic      res_valid,
	input  logic      res_ready,
	output pipe_ctl_t ctl
);

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] rdy;

	// A stage takes new contents when it is empty or its contents move on.
	always_comb begin
		rdy[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || res_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
	end

	assign pix_ready = rdy[0];
	assign res_valid = valid_q[NUM_STAGES-1];
	assign ctl.load = rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[0]) begin
				valid_q[0] <= pix_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

endmodule

/* rtl/cmob_datapath.sv */
module cmob_datapath
	import cmob_pkg::*;
(
	input  logic      clk,
	input  cfg_t      cfg,
	input  pipe_ctl_t ctl,
	input  pix_item_t pix,
	output res_item_t res
);

	logic signed [13:0] bx;
	logic signed [13:0] by;
	logic               in_buf;
	logic [7:0]         col;
	logic [7:0]         row;
	logic [7:0]         inv;

	logic        inside_s1;
	logic [12:0] bx_s1;
	logic [12:0] by_s1;
	logic [15:0] prod_a_s1;
	logic [31:0] dst_s1;

	logic        inside_s2;
	logic [7:0]  srca_s2;
	logic [25:0] rowoff_s2;
	logic [12:0] bx_s2;
	logic [31:0] dst_s2;

	logic            we_s3;
	logic [7:0]      srca_s3;
	logic [2:0][15:0] fgp_s3;
	logic [3:0][15:0] dsp_s3;
	logic [23:0]     addr_s3;
	logic [31:0]     dst_s3;

	logic [8:0] sum_a;
	logic [8:0] sum_r;
	logic [8:0] sum_g;
	logic [8:0] sum_b;

	res_item_t res_s4;

	assign col = pix.icon_col & ICON_MASK;
	assign row = pix.icon_row & ICON_MASK;
	assign bx = $signed({cfg.origin_x[12], cfg.origin_x}) + $signed({6'd0, col});
	assign by = $signed({cfg.origin_y[12], cfg.origin_y}) + $signed({6'd0, row});
	assign in_buf = !bx[13] && !by[13] &&
		(bx[12:0] < clamp_dim(cfg.buf_width)) &&
		(by[12:0] < clamp_dim(cfg.buf_height));

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			inside_s1 <= in_buf;
			bx_s1     <= bx[12:0];
			by_s1     <= by[12:0];
			prod_a_s1 <= cfg.fg_argb[31:24] * pix.coverage;
			dst_s1    <= pix.dest_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			inside_s2 <= inside_s1;
			srca_s2   <= div255(prod_a_s1);
			rowoff_s2 <= by_s1 * cfg.row_stride;
			bx_s2     <= bx_s1;
			dst_s2    <= dst_s1;
		end
	end

	assign inv = ALPHA_MAX - srca_s2;

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			we_s3   <= inside_s2 && (srca_s2 != 8'd0);
			srca_s3 <= srca_s2;
			for (int c = 0; c < 3; c++) begin
				fgp_s3[c] <= cfg.fg_argb[8*c +: 8] * srca_s2;
			end
			for (int c = 0; c < 4; c++) begin
				dsp_s3[c] <= dst_s2[8*c +: 8] * inv;
			end
			addr_s3 <= 24'(rowoff_s2 + 26'(bx_s2));
			dst_s3  <= dst_s2;
		end
	end

	assign sum_a = 9'(srca_s3) + 9'(div255(dsp_s3[3]));
	assign sum_r = 9'(div255(fgp_s3[2])) + 9'(div255(dsp_s3[2]));
	assign sum_g = 9'(div255(fgp_s3[1])) + 9'(div255(dsp_s3[1]));
	assign sum_b = 9'(div255(fgp_s3[0])) + 9'(div255(dsp_s3[0]));

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			res_s4.write_enable  <= we_s3;
			res_s4.pixel_address <= we_s3 ? addr_s3 : 24'd0;
			res_s4.out_pixel     <= we_s3 ?
				{sum_a[7:0], sum_r[7:0], sum_g[7:0], sum_b[7:0]} : dst_s3;
		end
	end

	assign res = res_s4;

endmodule

/* rtl/coverage_mask_over_blend_top.sv */
// Channel   Signals                          Transfer when
// pixel in  pix_valid, pix_ready, pix        pix_valid && pix_ready
// result    res_valid, res_ready, res        res_valid && res_ready
// config    psel, penable, pwrite, paddr,    psel && penable && pwrite
//           pwdata, prdata, pready
//
// One pixel is accepted per cycle while pix_ready is high; a stalled result can hold it low.
// The four register stages are clip and alpha product, alpha divide and row multiply,
// channel multiplies, then divide, sum and output register.
// Reset clears the stage valid bits and the configuration registers.
// A stalled result holds its stage; empty stages ahead of it keep accepting pixels.
module coverage_mask_over_blend_top
	import cmob_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  pix_item_t         pix,
	output logic              res_valid,
	input  logic              res_ready,
	output res_item_t         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t      cfg;
	pipe_ctl_t ctl;

	cmob_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cmob_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.ctl       (ctl)
	);

	cmob_datapath u_dp (
		.clk (clk),
		.cfg (cfg),
		.ctl (ctl),
		.pix (pix),
		.res (res)
	);

endmodule

/* tb/tb.sv */
module tb;
	import cmob_pkg::*;

	localparam int IDLE_PCT = 29;
	localparam int RAND_PHASES = 8;
	localparam int PIXELS_PER_PHASE = 204;
	localparam int UNMAPPED_IDX = NUM_REGS;
	localparam int MAX_REPORTS = 10;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              pix_valid = 1'b0;
	logic              pix_ready;
	pix_item_t         pix = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	res_item_t         res;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	pix_item_t pixel_queue[$];
	res_item_t pending_blends[$];
	cfg_t      shadow_cfg = '0;
	bit        no_gaps = 1'b0;
	int        mismatch_count = 0;

	coverage_mask_over_blend_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned scale255(int unsigned a, int unsigned b);
		return (a * b) / 255;
	endfunction

	function automatic res_item_t blend_pixel(pix_item_t p);
		int          bx, by, w, h;
		int unsigned sa, inv, oa, orr, og, ob;
		longint      addr;
		res_item_t   r;
		bx = int'($signed(shadow_cfg.origin_x)) + int'(p.icon_col);
		by = int'($signed(shadow_cfg.origin_y)) + int'(p.icon_row);
		w = (shadow_cfg.buf_width > MAX_DIM) ? MAX_DIM : int'(shadow_cfg.buf_width);
		h = (shadow_cfg.buf_height > MAX_DIM) ? MAX_DIM : int'(shadow_cfg.buf_height);
		sa = scale255(shadow_cfg.fg_argb[31:24], p.coverage);
		r.write_enable = 1'b0;
		r.pixel_address = '0;
		r.out_pixel = p.dest_pixel;
		if (bx >= 0 && by >= 0 && bx < w && by < h && sa != 0) begin
			inv = 255 - sa;
			oa = sa + scale255(p.dest_pixel[31:24], inv);
			orr = scale255(shadow_cfg.fg_argb[23:16], sa) +
				scale255(p.dest_pixel[23:16], inv);
			og = scale255(shadow_cfg.fg_argb[15:8], sa) +
				scale255(p.dest_pixel[15:8], inv);
			ob = scale255(shadow_cfg.fg_argb[7:0], sa) +
				scale255(p.dest_pixel[7:0], inv);
			addr = longint'(by) * longint'(shadow_cfg.row_stride) + longint'(bx);
			r.write_enable = 1'b1;
			r.pixel_address = 24'(addr);
			r.out_pixel = {8'(oa), 8'(orr), 8'(og), 8'(ob)};
		end
		return r;
	endfunction

	task automatic check_blend(res_item_t got);
		res_item_t want;
		if (pending_blends.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("Unexpected result transfer: we=%0b addr=%06h pixel=%08h",
					got.write_enable, got.pixel_address, got.out_pixel);
			return;
		end
		want = pending_blends.pop_front();
		if (got.write_enable !== want.write_enable ||
			got.pixel_address !== want.pixel_address ||
			got.out_pixel !== want.out_pixel) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("Mismatch: exp we=%0b addr=%06h pix=%08h, got we=%0b addr=%06h pix=%08h",
					want.write_enable, want.pixel_address, want.out_pixel,
					got.write_enable, got.pixel_address, got.out_pixel);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			pix <= '0;
		end else begin
			if (pix_valid && pix_ready)
				pending_blends.push_back(blend_pixel(pix));
			if (!pix_valid || pix_ready) begin
				if (pixel_queue.size() > 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
					pix_valid <= 1'b1;
					pix <= pixel_queue.pop_front();
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			res_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
			if (res_valid && res_ready)
				check_blend(res);
		end
	end

	task automatic reg_write(int unsigned idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FG_ARGB:    shadow_cfg.fg_argb = value;
			REG_ORIGIN_X:   shadow_cfg.origin_x = value[12:0];
			REG_ORIGIN_Y:   shadow_cfg.origin_y = value[12:0];
			REG_BUF_WIDTH:  shadow_cfg.buf_width = value[12:0];
			REG_BUF_HEIGHT: shadow_cfg.buf_height = value[12:0];
			REG_ROW_STRIDE: shadow_cfg.row_stride = value[12:0];
			default: ;
		endcase
	endtask

	// Upper bits of the 13-bit registers carry random data that must be ignored.
	task automatic configure(logic [31:0] fg, int ox, int oy, int w, int h, int stride);
		logic [31:0] d;
		reg_write(REG_FG_ARGB, fg);
		d = $urandom; d[12:0] = 13'(ox); reg_write(REG_ORIGIN_X, d);
		d = $urandom; d[12:0] = 13'(oy); reg_write(REG_ORIGIN_Y, d);
		d = $urandom; d[12:0] = 13'(w); reg_write(REG_BUF_WIDTH, d);
		d = $urandom; d[12:0] = 13'(h); reg_write(REG_BUF_HEIGHT, d);
		d = $urandom; d[12:0] = 13'(stride); reg_write(REG_ROW_STRIDE, d);
	endtask

	task automatic add_pixel(int col, int row, int cov, logic [31:0] dest);
		pix_item_t p;
		p.icon_col = 8'(col);
		p.icon_row = 8'(row);
		p.coverage = 8'(cov);
		p.dest_pixel = dest;
		pixel_queue.push_back(p);
	endtask

	task automatic wait_drained();
		while (pixel_queue.size() != 0 || pix_valid || pending_blends.size() != 0)
			@(negedge clk);
		repeat (NUM_STAGES + 2) @(posedge clk);
	endtask

	// Most coordinates are chosen so that the pixel lands inside the buffer.
	function automatic int pick_coord(int org, int dim);
		int d, t;
		d = (dim > MAX_DIM) ? MAX_DIM : dim;
		if (d > 0 && $urandom_range(99) < 75) begin
			t = int'($urandom_range(d - 1)) - org;
			if (t >= 0 && t <= 255)
				return t;
		end
		return $urandom_range(255);
	endfunction

	function automatic int pick_coverage();
		case ($urandom_range(9))
			0: return 0;
			1: return 255;
			default: return $urandom_range(255);
		endcase
	endfunction

	initial begin
		int          ox, oy, w, h, stride;
		logic [31:0] fg;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		add_pixel(0, 0, 255, 32'h1234_5678);
		add_pixel(255, 255, 255, 32'hffff_ffff);
		wait_drained();

		configure(32'hffc0_8040, -2, -3, 10, 8, 16);
		add_pixel(0, 0, 255, 32'h0000_0000);
		add_pixel(2, 3, 255, 32'h0000_0000);
		add_pixel(11, 3, 255, 32'hffff_ffff);
		add_pixel(12, 3, 255, 32'h8080_8080);
		add_pixel(2, 10, 200, 32'h1122_3344);
		add_pixel(2, 11, 200, 32'h1122_3344);
		add_pixel(1, 5, 255, 32'h5566_7788);
		add_pixel(5, 2, 255, 32'h5566_7788);
		add_pixel(5, 5, 0, 32'hdead_beef);
		add_pixel(5, 5, 1, 32'hffff_ffff);
		add_pixel(6, 6, 128, 32'h0000_0000);
		add_pixel(7, 7, 254, 32'hffff_ffff);
		add_pixel(255, 255, 255, 32'h0f0f_0f0f);
		add_pixel(11, 10, 77, 32'ha5a5_5a5a);
		wait_drained();

		configure(32'h00ff_ffff, 0, 0, 64, 64, 64);
		add_pixel(5, 5, 255, 32'h1234_5678);
		add_pixel(0, 0, 128, 32'h8765_4321);
		wait_drained();

		// Oversized dimensions clip at the maximum and the address wraps.
		configure(32'hff10_2030, 3840, 3840, 8191, 4096, 8191);
		add_pixel(255, 255, 255, 32'h0000_0000);
		add_pixel(0, 0, 1, 32'hffff_ffff);
		add_pixel(255, 0, 200, 32'hc3c3_3c3c);
		wait_drained();

		configure(32'h80ff_00ff, -4096, 4095, 0, 4096, 0);
		reg_write(UNMAPPED_IDX, $urandom);
		reg_write(UNMAPPED_IDX + 1, $urandom);
		add_pixel(255, 0, 255, 32'h0102_0304);
		wait_drained();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			fg = $urandom;
			if (ph == RAND_PHASES - 2) begin
				ox = $urandom_range(3500, 4095);
				oy = $urandom_range(3500, 4095);
				w = $urandom_range(MAX_DIM, 8191);
				h = $urandom_range(MAX_DIM, 8191);
				stride = $urandom_range(MAX_DIM, 8191);
			end else if (ph % 4 == 3) begin
				ox = int'($urandom_range(8191)) - 4096;
				oy = int'($urandom_range(8191)) - 4096;
				w = $urandom_range(8191);
				h = $urandom_range(8191);
				stride = $urandom_range(8191);
			end else begin
				ox = int'($urandom_range(128)) - 64;
				oy = int'($urandom_range(128)) - 64;
				w = $urandom_range(16, 300);
				h = $urandom_range(16, 300);
				stride = w + $urandom_range(64);
			end
			if (ph == 1)
				fg[31:24] = 8'hff;
			no_gaps = (ph == 2);
			configure(fg, ox, oy, w, h, stride);
			for (int i = 0; i < PIXELS_PER_PHASE; i++)
				add_pixel(pick_coord(ox, w), pick_coord(oy, h), pick_coverage(), $urandom);
			wait_drained();
		end

		if (mismatch_count == 0 && pending_blends.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#3_200_000;
		$display("Verification failed");
		$finish;
	end

endmodule
